@@ design/mdq_pkg.sv @@
// Shared types and codes of the multi-deque manager.
// Used by the controller, the datapath, the top level and the checker.
package mdq_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;
   localparam int QIN_W      = 8;
   localparam int VAL_W      = 31;

   localparam logic [1:0] OPC_PUSH  = 2'd0;
   localparam logic [1:0] OPC_POP   = 2'd1;
   localparam logic [1:0] OPC_MERGE = 2'd2;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;
   localparam logic [1:0] STS_SAME  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_DECIDE, ST_PUSH_FREE, ST_PUSH_LINK,
      ST_PUSH_FIX, ST_POP_RD, ST_POP_FREE, ST_REV_RD, ST_REV_WR, ST_MERGE_LINK,
      ST_MERGE_CLR, ST_DONE
   } mdq_state_type;

   typedef enum logic [3:0] {
      CMD_NOP, CMD_CLEAR, CMD_ACCEPT, CMD_RD_A, CMD_RD_B, CMD_DECIDE, CMD_PUSH_FREE,
      CMD_PUSH_LINK, CMD_PUSH_FIX, CMD_POP_RD, CMD_POP_FREE, CMD_REV_RD, CMD_REV_WR,
      CMD_MERGE_LINK, CMD_MERGE_CLR, CMD_RESULT
   } mdq_cmd_type;

   typedef struct packed {
      mdq_cmd_type cmd;
      logic        req_ready;
   } mdq_ctl_type;

   typedef struct packed {
      logic       clr_last;
      logic       rsp_free;
      logic [1:0] opcode;
      logic       at_back;
      logic       same_q;
      logic       pop_empty;
      logic       b_empty;
      logic       have_rec;
      logic       have_fresh;
      logic       walk_end;
   } mdq_sts_type;

endpackage

@@ design/mdq_ctrl.sv @@
// Sequencer of the multi-deque manager: steps each transaction through its
// memory accesses. Depends on mdq_pkg.
module mdq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  mdq_pkg::mdq_sts_type sts,
   output mdq_pkg::mdq_ctl_type ctl
);
   import mdq_pkg::*;

   mdq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:       if (req_tvalid) state_in = ST_RD_A;
         ST_RD_A:       state_in = ST_RD_B;
         ST_RD_B:       state_in = ST_DECIDE;
         ST_DECIDE: begin
            case (sts.opcode)
               OPC_PUSH: begin
                  if (sts.have_rec) state_in = ST_PUSH_FREE;
                  else if (sts.have_fresh) state_in = ST_PUSH_LINK;
                  else state_in = ST_DONE;
               end
               OPC_POP:  state_in = sts.pop_empty ? ST_DONE : ST_POP_RD;
               OPC_MERGE: begin
                  if (sts.same_q || sts.b_empty) state_in = ST_DONE;
                  else if (sts.at_back) state_in = ST_REV_RD;
                  else state_in = ST_MERGE_LINK;
               end
               default:  state_in = ST_DONE;
            endcase
         end
         ST_PUSH_FREE:  state_in = ST_PUSH_LINK;
         ST_PUSH_LINK:  state_in = ST_PUSH_FIX;
         ST_PUSH_FIX:   state_in = ST_DONE;
         ST_POP_RD:     state_in = ST_POP_FREE;
         ST_POP_FREE:   state_in = ST_DONE;
         ST_REV_RD:     state_in = ST_REV_WR;
         ST_REV_WR:     state_in = sts.walk_end ? ST_MERGE_LINK : ST_REV_RD;
         ST_MERGE_LINK: state_in = ST_MERGE_CLR;
         ST_MERGE_CLR:  state_in = ST_DONE;
         ST_DONE:       if (sts.rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.req_ready = 1'b0;
      ctl.cmd       = CMD_NOP;
      unique case (state_ff)
         ST_CLEAR:      ctl.cmd = CMD_CLEAR;
         ST_IDLE: begin
            ctl.cmd       = CMD_ACCEPT;
            ctl.req_ready = 1'b1;
         end
         ST_RD_A:       ctl.cmd = CMD_RD_A;
         ST_RD_B:       ctl.cmd = CMD_RD_B;
         ST_DECIDE:     ctl.cmd = CMD_DECIDE;
         ST_PUSH_FREE:  ctl.cmd = CMD_PUSH_FREE;
         ST_PUSH_LINK:  ctl.cmd = CMD_PUSH_LINK;
         ST_PUSH_FIX:   ctl.cmd = CMD_PUSH_FIX;
         ST_POP_RD:     ctl.cmd = CMD_POP_RD;
         ST_POP_FREE:   ctl.cmd = CMD_POP_FREE;
         ST_REV_RD:     ctl.cmd = CMD_REV_RD;
         ST_REV_WR:     ctl.cmd = CMD_REV_WR;
         ST_MERGE_LINK: ctl.cmd = CMD_MERGE_LINK;
         ST_MERGE_CLR:  ctl.cmd = CMD_MERGE_CLR;
         ST_DONE:       ctl.cmd = CMD_RESULT;
         default:       ctl.cmd = CMD_NOP;
      endcase
   end

endmodule

@@ design/mdq_datapath.sv @@
// Datapath of the multi-deque manager: queue table, node link and value
// memories, free-node tracking and the result register. Depends on mdq_pkg.
module mdq_datapath #(
   parameter int NUM_QUEUES = 256,
   parameter int NODE_COUNT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mdq_pkg::mdq_ctl_type                ctl,
   output mdq_pkg::mdq_sts_type                sts,
   input  logic                                req_tvalid,
   input  logic [mdq_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [mdq_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mdq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [mdq_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import mdq_pkg::*;

   localparam int QW = $clog2(NUM_QUEUES);
   localparam int NW = $clog2(NODE_COUNT + 1);
   localparam int AW = $clog2(NODE_COUNT);
   localparam logic [NW-1:0] NIL   = NW'(NODE_COUNT);
   localparam logic [QW-1:0] QLAST = QW'(NUM_QUEUES - 1);

   // Reduces a raw queue number by restoring subtraction of scaled counts.
   function automatic logic [QW-1:0] fold_queue(input logic [QIN_W-1:0] q);
      logic [31:0] x;
      logic [31:0] d;
      x = 32'(q);
      for (int k = QIN_W - 1; k >= 0; k--) begin
         d = 32'(NUM_QUEUES) << k;
         if (x >= d) x = x - d;
      end
      return x[QW-1:0];
   endfunction

   logic [2*NW-1:0]  qtab_mem [NUM_QUEUES];
   logic [NW-1:0]    next_mem [NODE_COUNT];
   logic [NW-1:0]    prev_mem [NODE_COUNT];
   logic [VAL_W-1:0] val_mem  [NODE_COUNT];

   logic [2*NW-1:0]  q_rd_ff;
   logic [NW-1:0]    nx_rd_ff, pv_rd_ff;
   logic [VAL_W-1:0] val_rd_ff;

   logic [1:0]       opc_ff, opc_in;
   logic             back_ff, back_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [QW-1:0]    qa_ff, qa_in, qb_ff, qb_in, clr_ff, clr_in;
   logic [NW-1:0]    a_head_ff, a_head_in, a_tail_ff, a_tail_in;
   logic [NW-1:0]    b_head_ff, b_head_in, b_tail_ff, b_tail_in;
   logic [NW-1:0]    n_ff, n_in, cur_ff, cur_in, rec_head_ff, rec_head_in, fill_ff, fill_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic [1:0]       res_sts_ff, res_sts_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic             q_we;
   logic [QW-1:0]    q_waddr, q_raddr;
   logic [2*NW-1:0]  q_wdata;
   logic             nx_we, pv_we, vl_we;
   logic [NW-1:0]    nx_waddr, pv_waddr, nx_wdata, pv_wdata, node_raddr;
   logic [NW-1:0]    pop_node, pop_m;
   logic             a_empty, rsp_free;

   assign pop_node = back_ff ? a_tail_ff : a_head_ff;
   assign pop_m    = back_ff ? pv_rd_ff : nx_rd_ff;
   assign a_empty  = (a_head_ff == NIL);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      opc_in = opc_ff;  back_in = back_ff;  val_in = val_ff;
      qa_in = qa_ff;  qb_in = qb_ff;  clr_in = clr_ff;
      a_head_in = a_head_ff;  a_tail_in = a_tail_ff;
      b_head_in = b_head_ff;  b_tail_in = b_tail_ff;
      n_in = n_ff;  cur_in = cur_ff;  rec_head_in = rec_head_ff;  fill_in = fill_ff;
      res_val_in = res_val_ff;  res_sts_in = res_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;  rsp_user_in = rsp_user_ff;
      q_we = 1'b0;  q_waddr = qa_ff;  q_raddr = qa_ff;  q_wdata = {NIL, NIL};
      nx_we = 1'b0;  nx_waddr = n_ff;  nx_wdata = NIL;
      pv_we = 1'b0;  pv_waddr = n_ff;  pv_wdata = NIL;
      vl_we = 1'b0;  node_raddr = cur_ff;
      unique case (ctl.cmd)
         CMD_NOP: ;
         CMD_CLEAR: begin
            q_we    = 1'b1;
            q_waddr = clr_ff;
            clr_in  = clr_ff + QW'(1);
         end
         CMD_ACCEPT: begin
            if (req_tvalid) begin
               opc_in     = req_tuser;
               qa_in      = fold_queue(req_tdata[7:0]);
               qb_in      = fold_queue(req_tdata[15:8]);
               back_in    = req_tdata[16];
               val_in     = req_tdata[47:17];
               res_val_in = '0;
               res_sts_in = STS_OK;
            end
         end
         CMD_RD_A: q_raddr = qa_ff;
         CMD_RD_B: begin
            q_raddr = qb_ff;
            {a_head_in, a_tail_in} = q_rd_ff;
         end
         CMD_DECIDE: begin
            {b_head_in, b_tail_in} = q_rd_ff;
            cur_in = q_rd_ff[2*NW-1:NW];
            case (opc_ff)
               OPC_PUSH: begin
                  if (rec_head_ff != NIL) begin
                     n_in       = rec_head_ff;
                     node_raddr = rec_head_ff;
                  end else if (fill_ff != NIL) begin
                     n_in    = fill_ff;
                     fill_in = fill_ff + NW'(1);
                  end else begin
                     res_sts_in = STS_FULL;
                  end
               end
               OPC_POP: begin
                  n_in       = pop_node;
                  node_raddr = pop_node;
                  if (pop_node == NIL) res_sts_in = STS_EMPTY;
               end
               OPC_MERGE: if (qa_ff == qb_ff) res_sts_in = STS_SAME;
               default: ;
            endcase
         end
         CMD_PUSH_FREE: rec_head_in = nx_rd_ff;
         CMD_PUSH_LINK: begin
            vl_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (back_ff) begin
               nx_wdata = NIL;
               pv_wdata = a_tail_ff;
            end else begin
               nx_wdata = a_head_ff;
               pv_wdata = NIL;
            end
         end
         CMD_PUSH_FIX: begin
            q_we = 1'b1;
            if (back_ff) begin
               nx_we    = !a_empty;
               nx_waddr = a_tail_ff;
               nx_wdata = n_ff;
               q_wdata  = {(a_empty ? n_ff : a_head_ff), n_ff};
            end else begin
               pv_we    = !a_empty;
               pv_waddr = a_head_ff;
               pv_wdata = n_ff;
               q_wdata  = {n_ff, (a_empty ? n_ff : a_tail_ff)};
            end
         end
         CMD_POP_RD: begin
            res_val_in = val_rd_ff;
            q_we       = 1'b1;
            if (back_ff) begin
               q_wdata  = {((pop_m == NIL) ? NIL : a_head_ff), pop_m};
               nx_we    = (pop_m != NIL);
               nx_waddr = pop_m;
            end else begin
               q_wdata  = {pop_m, ((pop_m == NIL) ? NIL : a_tail_ff)};
               pv_we    = (pop_m != NIL);
               pv_waddr = pop_m;
            end
         end
         CMD_POP_FREE: begin
            nx_we       = 1'b1;
            nx_wdata    = rec_head_ff;
            rec_head_in = n_ff;
         end
         CMD_REV_RD: node_raddr = cur_ff;
         CMD_REV_WR: begin
            nx_we    = 1'b1;
            nx_waddr = cur_ff;
            nx_wdata = pv_rd_ff;
            pv_we    = 1'b1;
            pv_waddr = cur_ff;
            pv_wdata = nx_rd_ff;
            cur_in   = nx_rd_ff;
            if (nx_rd_ff == NIL) begin
               b_head_in = b_tail_ff;
               b_tail_in = b_head_ff;
            end
         end
         CMD_MERGE_LINK: begin
            q_we = 1'b1;
            if (a_empty) begin
               q_wdata = {b_head_ff, b_tail_ff};
            end else begin
               nx_we    = 1'b1;
               nx_waddr = a_tail_ff;
               nx_wdata = b_head_ff;
               pv_we    = 1'b1;
               pv_waddr = b_head_ff;
               pv_wdata = a_tail_ff;
               q_wdata  = {a_head_ff, b_tail_ff};
            end
         end
         CMD_MERGE_CLR: begin
            q_we    = 1'b1;
            q_waddr = qb_ff;
         end
         CMD_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_val_ff};
               rsp_user_in  = res_sts_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rec_head_ff  <= NIL;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rec_head_ff  <= rec_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opc_ff      <= opc_in;
      back_ff     <= back_in;
      val_ff      <= val_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      a_head_ff   <= a_head_in;
      a_tail_ff   <= a_tail_in;
      b_head_ff   <= b_head_in;
      b_tail_ff   <= b_tail_in;
      n_ff        <= n_in;
      cur_ff      <= cur_in;
      res_val_ff  <= res_val_in;
      res_sts_ff  <= res_sts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) qtab_mem[q_waddr] <= q_wdata;
      q_rd_ff <= qtab_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (nx_we) next_mem[nx_waddr[AW-1:0]] <= nx_wdata;
      nx_rd_ff <= next_mem[node_raddr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pv_we) prev_mem[pv_waddr[AW-1:0]] <= pv_wdata;
      pv_rd_ff <= prev_mem[node_raddr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (vl_we) val_mem[n_ff[AW-1:0]] <= val_ff;
      val_rd_ff <= val_mem[node_raddr[AW-1:0]];
   end

   assign sts.clr_last   = (clr_ff == QLAST);
   assign sts.rsp_free   = rsp_free;
   assign sts.opcode     = opc_ff;
   assign sts.at_back    = back_ff;
   assign sts.same_q     = (qa_ff == qb_ff);
   assign sts.pop_empty  = (pop_node == NIL);
   assign sts.b_empty    = (q_rd_ff[2*NW-1:NW] == NIL);
   assign sts.have_rec   = (rec_head_ff != NIL);
   assign sts.have_fresh = (fill_ff != NIL);
   assign sts.walk_end   = (nx_rd_ff == NIL);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/multi_deque_manager.sv @@
// Top level of the multi-deque manager.
// Depends on mdq_pkg, mdq_ctrl and mdq_datapath.
//
// Double-ended queues sharing one pool of doubly linked nodes. Each request
// transaction pushes, pops or merges and yields exactly one response. After
// reset the block empties the queue table before req_tready first rises.
// Requests are processed one at a time: a push takes a recycled node off the
// free list first if there is one, a reversed merge rewrites the source
// queue node by node first, and a rejected request goes straight to the
// result. A finished response waits in the output register while the next
// request is accepted.
module multi_deque_manager #(
   parameter int NUM_QUEUES = 256,
   parameter int NODE_COUNT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // queue_a [7:0], queue_b [15:8], at_back [16], value [47:17]
   input  logic [mdq_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode [1:0]
   input  logic [mdq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // popped_value [30:0], zero [31]
   output logic [mdq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [mdq_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mdq_pkg::*;

   mdq_ctl_type ctl;
   mdq_sts_type sts;

   mdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .ctl        (ctl)
   );

   mdq_datapath #(
      .NUM_QUEUES (NUM_QUEUES),
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = ctl.req_ready;

endmodule

@@ design/mdq_checker.sv @@
// Port-level checks of the multi-deque manager, bound to the top level.
// Depends on mdq_pkg and multi_deque_manager.
module mdq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mdq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mdq_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mdq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while one is in progress");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != '0) |-> rsp_tuser == STS_OK)
      else $error("nonzero value on a failed request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind multi_deque_manager mdq_checker u_mdq_checker (.*);

@@ tb/sv/multi_deque_manager_tb.sv @@
// Self-checking testbench of the multi-deque manager: drives request transactions,
// predicts every response with a behavioral deque model and compares. Depends on mdq_pkg.
module multi_deque_manager_tb;
   import mdq_pkg::*;

   localparam int NQ    = 256;
   localparam int NODES = 4096;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam logic [1:0] OPC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   multi_deque_manager u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // Model of the queues: each deque as a SystemVerilog queue plus a node budget.
   logic [VAL_W-1:0] deque_q [NQ][$];
   int nodes_used = 0;
   logic [RSP_DATA_W-1:0] exp_value_q [$];
   logic [1:0] exp_status_q [$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int same_seen = 0;
   int empty_seen = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit stimulus_done = 1'b0;

   function automatic void predict_request(logic [1:0] opc, logic [7:0] qa, logic [7:0] qb,
                                           logic back, logic [VAL_W-1:0] val);
      logic [VAL_W-1:0] popped;
      logic [1:0] sts;
      logic [VAL_W-1:0] moved [$];
      popped = '0;
      sts = STS_OK;
      case (opc)
         OPC_PUSH: begin
            if (nodes_used >= NODES) begin
               sts = STS_FULL;
            end else begin
               nodes_used++;
               if (back) deque_q[qa].insert(deque_q[qa].size(), val);
               else deque_q[qa].insert(0, val);
            end
         end
         OPC_POP: begin
            if (deque_q[qa].size() == 0) begin
               sts = STS_EMPTY;
            end else begin
               nodes_used--;
               if (back) begin
                  popped = deque_q[qa][$];
                  deque_q[qa].delete(deque_q[qa].size() - 1);
               end else begin
                  popped = deque_q[qa][0];
                  deque_q[qa].delete(0);
               end
            end
         end
         OPC_MERGE: begin
            if (qa == qb) begin
               sts = STS_SAME;
            end else begin
               moved = deque_q[qb];
               deque_q[qb].delete();
               for (int k = 0; k < moved.size(); k++)
                  deque_q[qa].insert(deque_q[qa].size(),
                                     back ? moved[moved.size() - 1 - k] : moved[k]);
            end
         end
         default: ;
      endcase
      exp_value_q.insert(exp_value_q.size(), {1'b0, popped});
      exp_status_q.insert(exp_status_q.size(), sts);
   endfunction

   task automatic send_request(logic [1:0] opc, logic [7:0] qa, logic [7:0] qb, logic back,
                               logic [VAL_W-1:0] val, bit allow_gap = 1'b1);
      int gap;
      gap = 0;
      if (allow_gap) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= opc;
      req_tdata <= {val, back, qb, qa};
      predict_request(opc, qa, qb, back, val);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (exp_status_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic test_directed();
      send_request(OPC_POP, 8'd0, 8'd0, 1'b0, '0);
      send_request(OPC_POP, 8'd255, 8'd0, 1'b1, '0);
      send_request(OPC_PUSH, 8'd0, 8'd0, 1'b0, {VAL_W{1'b1}});
      send_request(OPC_PUSH, 8'd0, 8'd0, 1'b1, '0);
      send_request(OPC_PUSH, 8'd0, 8'd0, 1'b0, 31'h2AAA_AAAA);
      send_request(OPC_PUSH, 8'd255, 8'hFF, 1'b1, 31'h5555_5555);
      send_request(OPC_PUSH, 8'd255, 8'h00, 1'b1, 31'h1234_5678);
      send_request(OPC_MERGE, 8'd0, 8'd0, 1'b0, '0);
      send_request(OPC_MERGE, 8'd255, 8'd255, 1'b1, '0);
      send_request(OPC_MERGE, 8'd1, 8'd2, 1'b0, '0);
      send_request(OPC_MERGE, 8'd1, 8'd255, 1'b1, '0);
      send_request(OPC_MERGE, 8'd1, 8'd0, 1'b0, '0);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b1, '0);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b0, '0);
      send_request(OPC_UNUSED, 8'd1, 8'd7, 1'b1, 31'h7FFF_0000);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b0, '0);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b1, '0);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b1, '0);
      send_request(OPC_POP, 8'd1, 8'd0, 1'b1, '0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [1:0] opc;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) opc = OPC_PUSH;
         else if (pick < 82) opc = OPC_POP;
         else if (pick < 97) opc = OPC_MERGE;
         else opc = OPC_UNUSED;
         if ($urandom_range(0, 4) == 0)
            send_request(opc, 8'($urandom), 8'($urandom), 1'($urandom), 31'($urandom));
         else
            send_request(opc, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                         1'($urandom), 31'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(540);
      wait_drained();
      test_random(540);
      wait_drained();
      stimulus_done = 1'b1;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                       $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (exp_status_q.size() == 0) begin
            $error("response transaction with nothing expected");
            errors++;
         end else begin
            if (rsp_tdata !== exp_value_q[0]) begin
               $error("popped_value expected %0h actual %0h", exp_value_q[0], rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== exp_status_q[0]) begin
               $error("status expected %0d actual %0d", exp_status_q[0], rsp_tuser);
               errors++;
            end
            if (exp_status_q[0] == STS_SAME) same_seen++;
            if (exp_status_q[0] == STS_EMPTY) empty_seen++;
            exp_value_q.delete(0);
            exp_status_q.delete(0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", exp_status_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      while (exp_status_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d requests sent, %0d responses checked", sent, received);
      $display("%0d empty-queue and %0d merge-onto-itself responses seen",
               empty_seen, same_seen);
      if (errors == 0 && exp_status_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
